// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BDLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BDLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bdlp_pkg.sv =====
// Package: shared types and constants for the button debounce / long-press block.
`default_nettype none

package bdlp_pkg;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int IDX_IN_W  = 3;
	localparam int CFG_IDX_W = 2;

	// Event codes reported per sample
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_LONG     = 3'd3,
		EV_REPEAT   = 3'd4
	} event_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_REPEAT     = 2'd2
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] repeat_ms;
	} cfg_t;

	// Per-button record
	typedef struct packed {
		logic              stable_level;
		logic [TIME_W-1:0] change_time;
		logic [TIME_W-1:0] repeat_time;
		event_t            held_event;
		logic              long_seen;
	} btn_rec_t;

	// Result of evaluating one sample against its button record
	typedef struct packed {
		logic     wr_en;
		btn_rec_t rec;
		event_t   ev;
	} eval_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdlp_cfg_regs.sv =====
// Configuration registers: debounce, long-press and repeat times.
`default_nettype none

module bdlp_cfg_regs
	import bdlp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.repeat_ms     <= REPEAT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DEBOUNCE:   cfg_q.debounce_ms   <= wr_data;
				CFG_LONG_PRESS: cfg_q.long_press_ms <= wr_data;
				CFG_REPEAT:     cfg_q.repeat_ms     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_btn_bank.sv =====
// Per-button record storage: one read port, one write port.
`default_nettype none

module bdlp_btn_bank
	import bdlp_pkg::*;
#(
	parameter int BUTTONS = 4,
	parameter int IDX_W   = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output btn_rec_t              rd_rec,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire btn_rec_t         wr_rec
);

	btn_rec_t rec_q [BUTTONS];

	// Records clear to zero on reset, updated one at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				rec_q[i] <= '0;
			end
		end else if (wr_en) begin
			rec_q[wr_idx] <= wr_rec;
		end
	end

	assign rd_rec = rec_q[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_event_eval.sv =====
// Event decision for one sample: debounce, edge, long press and repeat.
`default_nettype none

module bdlp_event_eval
	import bdlp_pkg::*;
(
	input  wire btn_rec_t           rec,
	input  wire logic               level,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic               in_range,
	input  wire cfg_t               cfg,
	output eval_res_t               res
);

	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_repeat;
	logic              in_window;
	logic              long_due;
	logic              repeat_due;

	// Wrapping time differences
	assign since_change = now_ms - rec.change_time;
	assign since_repeat = now_ms - rec.repeat_time;
	assign in_window    = since_change < TIME_W'(cfg.debounce_ms);
	assign long_due     = !rec.long_seen && (since_change >= TIME_W'(cfg.long_press_ms));
	assign repeat_due   = rec.long_seen && (since_repeat >= TIME_W'(cfg.repeat_ms));

	always_comb begin
		res.wr_en = 1'b0;
		res.rec   = rec;
		res.ev    = rec.held_event;
		if (!in_range) begin
			res.ev = EV_NONE;
		end else if (in_window) begin
			// inside debounce window: repeat stored event
			res.ev = rec.held_event;
		end else if (level != rec.stable_level) begin
			// accepted level change
			res.wr_en                = 1'b1;
			res.rec.stable_level     = level;
			res.rec.change_time      = now_ms;
			res.rec.long_seen        = 1'b0;
			res.rec.held_event       = level ? EV_PRESSED : EV_RELEASED;
			res.ev                   = res.rec.held_event;
		end else if (level) begin
			if (long_due) begin
				res.wr_en              = 1'b1;
				res.rec.long_seen      = 1'b1;
				res.rec.repeat_time    = now_ms;
				res.rec.held_event     = EV_LONG;
				res.ev                 = EV_LONG;
			end else if (repeat_due) begin
				res.wr_en              = 1'b1;
				res.rec.repeat_time    = now_ms;
				res.rec.held_event     = EV_REPEAT;
				res.ev                 = EV_REPEAT;
			end
		end else begin
			// released and steady
			res.wr_en              = 1'b1;
			res.rec.held_event     = EV_NONE;
			res.ev                 = EV_NONE;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/button_debounce_long_press_top.sv =====
// An input transfer loads the input register stage, which feeds the result register that drives out_valid.
// Throughput: one sample per cycle while no result is stalled; the button record is read from the input
// register stage and written back as the result register loads.
// Output stall holds the result register, then the input stage, then in_stall.
// Reset (arst_n low, async) clears all button records and loads the default
// debounce 50, long press 1000 and repeat 200 ms.
`default_nettype none

module button_debounce_long_press_top
	import bdlp_pkg::*;
#(
	parameter int BUTTONS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// sample channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [IDX_IN_W-1:0]  button_index,
	input  wire logic                 level,
	input  wire logic [TIME_W-1:0]    now_ms,
	// event channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                event_res,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	cfg_t              cfg;
	btn_rec_t          rd_rec;
	eval_res_t         res;

	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              in_range_s1;
	logic              level_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_valid_q;
	event_t            event_q;

	logic              in_range;
	logic              out_free;
	logic              adv_s1;
	logic              in_xfer;

	// Handshake control
	assign in_range  = {1'b0, button_index} < (IDX_IN_W + 1)'(BUTTONS);
	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_s1      <= button_index[IDX_W-1:0];
			in_range_s1 <= in_range;
			level_s1    <= level;
			now_s1      <= now_ms;
		end
	end

	bdlp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bdlp_btn_bank #(
		.BUTTONS (BUTTONS),
		.IDX_W   (IDX_W)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_s1),
		.rd_rec (rd_rec),
		.wr_en  (adv_s1 && res.wr_en),
		.wr_idx (idx_s1),
		.wr_rec (res.rec)
	);

	bdlp_event_eval u_eval (
		.rec      (rd_rec),
		.level    (level_s1),
		.now_ms   (now_s1),
		.in_range (in_range_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_q <= res.ev;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_checker.sv =====
// Port-level checker for the button debounce / long-press top, with its bind.
`default_nettype none
`include "assert_macros.svh"

module bdlp_checker
	import bdlp_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [2:0]           event_res,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready
);

	// Input backs up only when a result is waiting and stalled
	`BDLP_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall), "in_stall without stalled result")

	// An accepted sample has a result showing once it has passed the input and result registers
	`BDLP_ASSERT(a_result_follows, clk, arst_n, (in_valid && !in_stall) |=> ##1 out_valid, "no result after sample transfer")

	// A stalled result holds its event code
	`BDLP_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(event_res)), "stalled result changed")

	// Configuration writes are never back-pressured
	`BDLP_ASSERT(a_cfg_ready, clk, arst_n, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.event_res (event_res),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== sim/bdlp_event_checker.sv =====
// Event checker: tracks button records, predicts each event code and compares it.
module bdlp_event_checker
	import bdlp_pkg::*;
#(
	parameter int BUTTONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [IDX_IN_W-1:0]  button_index,
	input  logic                 level,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [2:0]           event_res,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	// Mirror of the timing registers
	logic [CFG_W-1:0] deb_win;
	logic [CFG_W-1:0] long_delay;
	logic [CFG_W-1:0] rep_gap;

	// Mirror of the per-button records
	logic              btn_level  [BUTTONS];
	logic [TIME_W-1:0] btn_change [BUTTONS];
	logic [TIME_W-1:0] btn_repeat [BUTTONS];
	event_t            btn_event  [BUTTONS];
	logic              btn_long   [BUTTONS];

	event_t expected_events [$];
	event_t want;
	int     k;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Event for one sample; updates the button record it touches
	function automatic event_t predict_event(input logic [IDX_IN_W-1:0] idx, input logic lvl,
			input logic [TIME_W-1:0] t);
		int b;
		logic [TIME_W-1:0] since_change;
		logic [TIME_W-1:0] since_repeat;
		if (idx >= BUTTONS)
			return EV_NONE;
		b = idx;
		since_change = t - btn_change[b];
		since_repeat = t - btn_repeat[b];
		// still bouncing: ignore the level
		if (since_change < {16'd0, deb_win})
			return btn_event[b];
		// accepted edge
		if (lvl != btn_level[b]) begin
			btn_level[b] = lvl;
			btn_change[b] = t;
			btn_long[b] = 1'b0;
			btn_event[b] = lvl ? EV_PRESSED : EV_RELEASED;
			return btn_event[b];
		end
		// released and steady
		if (!lvl) begin
			btn_event[b] = EV_NONE;
			return EV_NONE;
		end
		// held
		if (!btn_long[b] && since_change >= {16'd0, long_delay}) begin
			btn_long[b] = 1'b1;
			btn_repeat[b] = t;
			btn_event[b] = EV_LONG;
			return EV_LONG;
		end
		if (btn_long[b] && since_repeat >= {16'd0, rep_gap}) begin
			btn_repeat[b] = t;
			btn_event[b] = EV_REPEAT;
			return EV_REPEAT;
		end
		return btn_event[b];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_win = DEBOUNCE_RST;
			long_delay = LONG_PRESS_RST;
			rep_gap = REPEAT_RST;
			for (k = 0; k < BUTTONS; k++) begin
				btn_level[k] = 1'b0;
				btn_change[k] = '0;
				btn_repeat[k] = '0;
				btn_event[k] = EV_NONE;
				btn_long[k] = 1'b0;
			end
			expected_events.delete();
			pending = 0;
		end else begin
			// result transfer: compare with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: event_res expected nothing, got %0d", $time, event_res);
				end else begin
					want = expected_events.pop_front();
					if (event_res !== want) begin
						fail_count++;
						$display("%0t: event_res expected %0d, got %0d", $time, want, event_res);
					end
				end
			end
			// register write; indexes past the list change nothing
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE:   deb_win = cfg_data;
					CFG_LONG_PRESS: long_delay = cfg_data;
					CFG_REPEAT:     rep_gap = cfg_data;
					default: ;
				endcase
			end
			// sample transfer
			if (in_valid && !in_stall)
				expected_events.push_back(predict_event(button_index, level, now_ms));
			pending = expected_events.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: clock, reset, sample and register stimulus, and the verdict.
module tb_top;
	import bdlp_pkg::*;

	localparam int BUTTONS = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;	// not a register
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 280;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [IDX_IN_W-1:0]  button_index;
	logic                 level;
	logic [TIME_W-1:0]    now_ms;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           event_res;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;

	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	// current timing, used to size the time steps
	int deb_ms = 50;
	int lp_ms = 1000;
	int rep_ms = 200;

	logic [TIME_W-1:0] clock_ms = '0;
	logic              btn_down [BUTTONS];

	button_debounce_long_press_top #(.BUTTONS(BUTTONS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.button_index(button_index),
		.level(level),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bdlp_event_checker #(.BUTTONS(BUTTONS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.button_index(button_index),
		.level(level),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	initial begin
		#3000000;
		$display("** button_debounce_long_press_top: FAILED **");
		$finish;
	end

	// event receiver: random stall, quiet stretch, one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (no_gaps)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	// one sample transfer, then maybe an idle gap
	task automatic send_sample(input logic [IDX_IN_W-1:0] idx, input logic lvl,
			input logic [TIME_W-1:0] t);
		@(negedge clk);
		in_valid <= 1'b1;
		button_index <= idx;
		level <= lvl;
		now_ms <= t;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		if (!no_gaps && $urandom_range(0, 99) < 10) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DEBOUNCE:   deb_ms = int'(val);
			CFG_LONG_PRESS: lp_ms = int'(val);
			CFG_REPEAT:     rep_ms = int'(val);
			default: ;
		endcase
	endtask

	// stop sending and let every expected event come out
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly press/hold/release patterns, some stray indexes and time jumps
	task automatic press_traffic(input int count);
		int pick;
		int span;
		int b;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: span = deb_ms + 1;
				1: span = rep_ms + 2;
				2: span = lp_ms + 2;
				default: span = 3;
			endcase
			clock_ms = clock_ms + $urandom_range(0, span);
			if (pick < 82) begin
				b = $urandom_range(0, BUTTONS - 1);
				if ($urandom_range(0, 99) < 25)
					btn_down[b] = !btn_down[b];
				send_sample(IDX_IN_W'(b), btn_down[b], clock_ms);
			end else if (pick < 92)
				send_sample(IDX_IN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					clock_ms);
			else begin
				clock_ms = $urandom();
				send_sample(IDX_IN_W'($urandom_range(0, BUTTONS - 1)),
					1'($urandom_range(0, 1)), clock_ms);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		button_index = '0;
		level = 1'b0;
		now_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEBOUNCE;
		cfg_data = '0;
		foreach (btn_down[i])
			btn_down[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timing: startup window, stray indexes, full press cycle
		send_sample(3'd0, 1'b0, 32'd0);
		send_sample(3'd1, 1'b1, 32'd10);
		send_sample(3'd4, 1'b1, 32'hFFFF_FFFF);
		send_sample(3'd7, 1'b0, 32'h1234_5678);
		send_sample(3'd0, 1'b1, 32'd100);
		send_sample(3'd0, 1'b0, 32'd120);
		send_sample(3'd0, 1'b1, 32'd1099);
		send_sample(3'd0, 1'b1, 32'd1100);
		send_sample(3'd0, 1'b1, 32'd1200);
		send_sample(3'd0, 1'b1, 32'd1300);
		send_sample(3'd0, 1'b1, 32'd1500);
		send_sample(3'd0, 1'b0, 32'd1600);
		send_sample(3'd0, 1'b0, 32'd1700);
		// long press measured across the time wrap
		send_sample(3'd2, 1'b1, 32'hFFFF_FFF0);
		send_sample(3'd2, 1'b1, 32'h0000_03E0);
		send_sample(3'd2, 1'b0, 32'h0000_0500);
		clock_ms = 32'd2000;
		press_traffic(PHASE_ITEMS);
		settle_idle();

		// zero timing: every eligible sample fires at once
		write_reg(CFG_DEBOUNCE, 16'd0);
		write_reg(CFG_LONG_PRESS, 16'd0);
		write_reg(CFG_REPEAT, 16'd0);
		send_sample(3'd1, 1'b1, clock_ms);
		send_sample(3'd1, 1'b1, clock_ms);
		send_sample(3'd1, 1'b1, clock_ms);
		send_sample(3'd1, 1'b0, clock_ms);
		send_sample(3'd1, 1'b0, clock_ms);
		press_traffic(PHASE_ITEMS);
		settle_idle();

		// widest timing, back-to-back transfers
		write_reg(CFG_DEBOUNCE, 16'hFFFF);
		write_reg(CFG_LONG_PRESS, 16'hFFFF);
		write_reg(CFG_REPEAT, 16'hFFFF);
		no_gaps = 1'b1;
		press_traffic(PHASE_ITEMS);
		settle_idle();
		no_gaps = 1'b0;

		// short timing near the wrap, output held off to back up the pipe
		write_reg(CFG_DEBOUNCE, 16'd3);
		write_reg(CFG_LONG_PRESS, 16'd20);
		write_reg(CFG_REPEAT, 16'd5);
		clock_ms = 32'hFFFF_FC00;
		hold_request = 1'b1;
		press_traffic(PHASE_ITEMS);
		settle_idle();

		// random timing; a write past the list must not disturb it
		write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 200)));
		write_reg(CFG_LONG_PRESS, CFG_W'($urandom_range(0, 3000)));
		write_reg(CFG_REPEAT, CFG_W'($urandom_range(0, 500)));
		write_reg(CFG_SPARE, 16'h0000);
		press_traffic(PHASE_ITEMS);
		settle_idle();

		if (fail_count == 0)
			$display("** button_debounce_long_press_top: PASSED **");
		else
			$display("** button_debounce_long_press_top: FAILED **");
		$finish;
	end

endmodule
